### sv/sha1s_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and functions of the SHA-1 stream hasher.
package sha1s_pkg;

   localparam int WORD_W   = 32;
   localparam int BYTE_W   = 8;
   localparam int CHAIN_N  = 5;
   localparam int CHAIN_AW = 3;
   localparam int BLK_N    = 16;
   localparam int BLK_AW   = 4;
   localparam int POS_W    = 6;
   localparam int CNT_W    = 7;
   localparam int COUNT_W  = 64;
   localparam int IDX_W    = 3;

   localparam logic [0:0] MODE_ABSORB = 1'b0;
   localparam logic [0:0] MODE_FINISH = 1'b1;

   localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;
   localparam logic [POS_W-1:0]  POS_LAST = 6'd63;
   localparam logic [POS_W-1:0]  POS_LEN  = 6'd56;

   localparam logic [CNT_W-1:0] LOAD_LAST   = 7'd16;
   localparam logic [CNT_W-1:0] ROUND_LAST  = 7'd79;
   localparam logic [CNT_W-1:0] FINAL_LAST  = 7'd5;
   localparam logic [CNT_W-1:0] ROUND_STG1  = 7'd20;
   localparam logic [CNT_W-1:0] ROUND_STG2  = 7'd40;
   localparam logic [CNT_W-1:0] ROUND_STG3  = 7'd60;

   localparam logic [IDX_W-1:0] IDX_LAST = 3'd4;

   localparam logic [WORD_W-1:0] K_STG0 = 32'h5A827999;
   localparam logic [WORD_W-1:0] K_STG1 = 32'h6ED9EBA1;
   localparam logic [WORD_W-1:0] K_STG2 = 32'h8F1BBCDC;
   localparam logic [WORD_W-1:0] K_STG3 = 32'hCA62C1D6;

   localparam logic [WORD_W-1:0] H0_INIT = 32'h67452301;
   localparam logic [WORD_W-1:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [WORD_W-1:0] H2_INIT = 32'h98BADCFE;
   localparam logic [WORD_W-1:0] H3_INIT = 32'h10325476;
   localparam logic [WORD_W-1:0] H4_INIT = 32'hC3D2E1F0;

   typedef struct packed {
      logic                put_en;
      logic [POS_W-1:0]    put_pos;
      logic [BYTE_W-1:0]   put_byte;
      logic                rd_en;
      logic [BLK_AW-1:0]   rd_addr;
   } blk_req_type;

   typedef struct packed {
      logic                rd_en;
      logic [CHAIN_AW-1:0] rd_addr;
      logic                wr_en;
      logic [CHAIN_AW-1:0] wr_addr;
      logic [WORD_W-1:0]   wr_data;
      logic                clear;
   } chain_req_type;

   typedef struct packed {
      logic             w_shift;
      logic             chain_shift;
      logic             step;
      logic [CNT_W-1:0] rnd;
   } round_ctl_type;

   function automatic logic [WORD_W-1:0] chain_init(input logic [CHAIN_AW-1:0] idx);
      logic [WORD_W-1:0] val;
      unique case (idx)
         3'd0: val = H0_INIT;
         3'd1: val = H1_INIT;
         3'd2: val = H2_INIT;
         3'd3: val = H3_INIT;
         3'd4: val = H4_INIT;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### sv/sha1s_block_store.sv
`timescale 1ns / 1ps
// Message block memory with big-endian byte packing.
module sha1s_block_store (
   input  logic                            clock,
   input  sha1s_pkg::blk_req_type          req,
   output logic [sha1s_pkg::WORD_W-1:0]    rd_data
);

   logic [sha1s_pkg::WORD_W-1:0] mem [sha1s_pkg::BLK_N];
   logic [sha1s_pkg::WORD_W-1:0] acc_ff;
   logic [sha1s_pkg::WORD_W-1:0] acc_in;
   logic [sha1s_pkg::WORD_W-1:0] bits;
   logic [sha1s_pkg::WORD_W-1:0] rd_q_ff;

   assign bits = {24'd0, req.put_byte} << {~req.put_pos[1:0], 3'b000};
   assign acc_in = (req.put_pos[1:0] == 2'd0) ? bits : (acc_ff | bits);

   always_ff @(posedge clock) begin
      if (req.put_en) begin
         acc_ff <= acc_in;
         if (req.put_pos[1:0] == 2'd3) begin
            mem[req.put_pos[5:2]] <= acc_in;
         end
      end
      if (req.rd_en) begin
         rd_q_ff <= mem[req.rd_addr];
      end
   end

   assign rd_data = rd_q_ff;

endmodule

### sv/sha1s_chain_store.sv
`timescale 1ns / 1ps
// Chaining word memory with per-entry valid bits that read back the initial values.
module sha1s_chain_store (
   input  logic                            clock,
   input  logic                            reset,
   input  sha1s_pkg::chain_req_type        req,
   output logic [sha1s_pkg::WORD_W-1:0]    rd_data
);

   logic [sha1s_pkg::WORD_W-1:0]   mem [sha1s_pkg::CHAIN_N];
   logic [sha1s_pkg::CHAIN_N-1:0]  valid_ff;
   logic [sha1s_pkg::WORD_W-1:0]   rd_q_ff;
   logic [sha1s_pkg::CHAIN_AW-1:0] rd_addr_ff;
   logic                           rd_valid_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_q_ff    <= mem[req.rd_addr];
         rd_addr_ff <= req.rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req.rd_en) begin
            rd_valid_ff <= valid_ff[req.rd_addr];
         end
         if (req.clear) begin
            valid_ff <= '0;
         end else if (req.wr_en) begin
            valid_ff[req.wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : sha1s_pkg::chain_init(rd_addr_ff);

endmodule

### sv/sha1s_round.sv
`timescale 1ns / 1ps
// Compression datapath: working variables, schedule window and one round per cycle.
module sha1s_round (
   input  logic                            clock,
   input  sha1s_pkg::round_ctl_type        ctl,
   input  logic [sha1s_pkg::WORD_W-1:0]    w_in,
   input  logic [sha1s_pkg::WORD_W-1:0]    chain_in,
   output logic [sha1s_pkg::WORD_W-1:0]    a_out
);

   logic [sha1s_pkg::WORD_W-1:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [sha1s_pkg::WORD_W-1:0] w_ff [sha1s_pkg::BLK_N];
   logic [sha1s_pkg::WORD_W-1:0] f_val;
   logic [sha1s_pkg::WORD_W-1:0] k_val;
   logic [sha1s_pkg::WORD_W-1:0] t_val;
   logic [sha1s_pkg::WORD_W-1:0] w_mix;
   logic [sha1s_pkg::WORD_W-1:0] w_new;

   always_comb begin
      priority if (ctl.rnd < sha1s_pkg::ROUND_STG1) begin
         f_val = d_ff ^ (b_ff & (c_ff ^ d_ff));
         k_val = sha1s_pkg::K_STG0;
      end else if (ctl.rnd < sha1s_pkg::ROUND_STG2) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1s_pkg::K_STG1;
      end else if (ctl.rnd < sha1s_pkg::ROUND_STG3) begin
         f_val = (b_ff & c_ff) | (d_ff & (b_ff | c_ff));
         k_val = sha1s_pkg::K_STG2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1s_pkg::K_STG3;
      end
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_ff[0];
   assign w_mix = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
   assign w_new = {w_mix[30:0], w_mix[31]};

   always_ff @(posedge clock) begin
      priority if (ctl.step) begin
         for (int i = 0; i < sha1s_pkg::BLK_N - 1; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[sha1s_pkg::BLK_N-1] <= w_new;
         a_ff <= t_val;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end else if (ctl.w_shift || ctl.chain_shift) begin
         if (ctl.w_shift) begin
            for (int i = 0; i < sha1s_pkg::BLK_N - 1; i++) begin
               w_ff[i] <= w_ff[i+1];
            end
            w_ff[sha1s_pkg::BLK_N-1] <= w_in;
         end
         if (ctl.chain_shift) begin
            a_ff <= b_ff;
            b_ff <= c_ff;
            c_ff <= d_ff;
            d_ff <= e_ff;
            e_ff <= chain_in;
         end
      end
   end

   assign a_out = a_ff;

endmodule

### sv/sha1_stream_hasher_top.sv
`timescale 1ns / 1ps
// Top level of the SHA-1 stream hasher: sequencer, padding and digest output.
//
//   channel | dir | fields
//   req_    | in  | tdata[7:0] data_byte, tuser[0] mode
//   rsp_    | out | tdata[31:0] digest_word, tdata[34:32] word_index, tlast last_word
//
// An absorb word is written straight into the block memory; the word that fills a block
// then starts block load, 80 rounds of the single round unit and chain write-back.
// A finish word pads one byte per cycle through the block memory (9 to 72 bytes,
// with one or two compressions), then reads the five digest words into the output register.
// Reset clears the sequencer and marks the chaining memory as holding its initial values.
// A stalled result waits in the output register and holds back the next digest word.
module sha1_stream_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, zero above
   output logic        rsp_tlast
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD,
      S_LOAD,
      S_ROUND,
      S_FINAL,
      S_EMIT,
      S_EMIT_LD
   } state_type;

   state_type                           state_ff, state_in;
   logic [sha1s_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [sha1s_pkg::POS_W-1:0]         pos_ff, pos_in;
   logic [sha1s_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic                                fin_ff, fin_in;
   logic                                len_ff, len_in;
   logic [sha1s_pkg::IDX_W-1:0]         emit_idx_ff, emit_idx_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [sha1s_pkg::WORD_W-1:0]        rsp_word_ff, rsp_word_in;
   logic [sha1s_pkg::IDX_W-1:0]         rsp_idx_ff, rsp_idx_in;
   logic                                rsp_last_ff, rsp_last_in;

   sha1s_pkg::blk_req_type              blk_req;
   sha1s_pkg::chain_req_type            chain_req;
   sha1s_pkg::round_ctl_type            round_ctl;
   logic [sha1s_pkg::WORD_W-1:0]        blk_rd_data;
   logic [sha1s_pkg::WORD_W-1:0]        chain_rd_data;
   logic [sha1s_pkg::WORD_W-1:0]        round_a;
   logic [sha1s_pkg::COUNT_W-1:0]       len_bits;
   logic [sha1s_pkg::BYTE_W-1:0]        len_byte;
   logic                                len_mode;
   logic                                req_fire;
   logic                                rsp_fire;

   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_valid_ff & rsp_tready;
   assign len_bits = {count_ff[60:0], 3'b000};
   assign len_byte = len_bits[{~pos_ff[2:0], 3'b000} +: 8];
   assign len_mode = len_ff | (pos_ff == sha1s_pkg::POS_LEN);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      fin_in       = fin_ff;
      len_in       = len_ff;
      emit_idx_in  = emit_idx_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      blk_req      = '0;
      chain_req    = '0;
      round_ctl    = '0;
      round_ctl.rnd = cnt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               blk_req.put_en  = 1'b1;
               blk_req.put_pos = pos_ff;
               pos_in          = pos_ff + 1'b1;
               cnt_in          = '0;
               if (req_tuser == sha1s_pkg::MODE_FINISH) begin
                  blk_req.put_byte = sha1s_pkg::PAD_BYTE;
                  fin_in           = 1'b1;
                  len_in           = 1'b0;
                  state_in         = S_PAD;
               end else begin
                  blk_req.put_byte = req_tdata;
                  count_in         = count_ff + 1'b1;
               end
               if (pos_ff == sha1s_pkg::POS_LAST) begin
                  state_in = S_LOAD;
               end
            end
         end
         S_PAD: begin
            blk_req.put_en   = 1'b1;
            blk_req.put_pos  = pos_ff;
            blk_req.put_byte = len_mode ? len_byte : '0;
            len_in           = len_mode;
            pos_in           = pos_ff + 1'b1;
            if (pos_ff == sha1s_pkg::POS_LAST) begin
               cnt_in   = '0;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            blk_req.rd_en         = (cnt_ff < 7'(sha1s_pkg::BLK_N));
            blk_req.rd_addr       = cnt_ff[sha1s_pkg::BLK_AW-1:0];
            chain_req.rd_en       = (cnt_ff < 7'(sha1s_pkg::CHAIN_N));
            chain_req.rd_addr     = cnt_ff[sha1s_pkg::CHAIN_AW-1:0];
            round_ctl.w_shift     = (cnt_ff != '0);
            round_ctl.chain_shift = (cnt_ff != '0) && (cnt_ff <= 7'(sha1s_pkg::CHAIN_N));
            cnt_in                = cnt_ff + 1'b1;
            if (cnt_ff == sha1s_pkg::LOAD_LAST) begin
               cnt_in   = '0;
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            round_ctl.step = 1'b1;
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == sha1s_pkg::ROUND_LAST) begin
               cnt_in   = '0;
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            chain_req.rd_en   = (cnt_ff < 7'(sha1s_pkg::CHAIN_N));
            chain_req.rd_addr = cnt_ff[sha1s_pkg::CHAIN_AW-1:0];
            if (cnt_ff != '0) begin
               chain_req.wr_en       = 1'b1;
               chain_req.wr_addr     = 3'(cnt_ff - 1'b1);
               chain_req.wr_data     = chain_rd_data + round_a;
               round_ctl.chain_shift = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == sha1s_pkg::FINAL_LAST) begin
               cnt_in = '0;
               priority if (fin_ff && len_ff) begin
                  emit_idx_in = '0;
                  state_in    = S_EMIT;
               end else if (fin_ff) begin
                  state_in = S_PAD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               chain_req.rd_en   = 1'b1;
               chain_req.rd_addr = emit_idx_ff;
               state_in          = S_EMIT_LD;
            end
         end
         S_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = chain_rd_data;
            rsp_idx_in   = emit_idx_ff;
            rsp_last_in  = (emit_idx_ff == sha1s_pkg::IDX_LAST);
            emit_idx_in  = emit_idx_ff + 1'b1;
            state_in     = S_EMIT;
            if (emit_idx_ff == sha1s_pkg::IDX_LAST) begin
               chain_req.clear = 1'b1;
               count_in        = '0;
               pos_in          = '0;
               fin_in          = 1'b0;
               len_in          = 1'b0;
               emit_idx_in     = '0;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         fin_ff       <= 1'b0;
         len_ff       <= 1'b0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         fin_ff       <= fin_in;
         len_ff       <= len_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   sha1s_block_store u_block (
      .clock   (clock),
      .req     (blk_req),
      .rd_data (blk_rd_data)
   );

   sha1s_chain_store u_chain (
      .clock   (clock),
      .reset   (reset),
      .req     (chain_req),
      .rd_data (chain_rd_data)
   );

   sha1s_round u_round (
      .clock    (clock),
      .ctl      (round_ctl),
      .w_in     (blk_rd_data),
      .chain_in (chain_rd_data),
      .a_out    (round_a)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_idx_ff, rsp_word_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

### sv/sha1s_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the SHA-1 stream hasher and its bind to the top level.
module sha1s_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic [sha1s_pkg::IDX_W-1:0] exp_idx_ff;
   logic                        rsp_fire;
   logic                        req_fire;

   assign rsp_fire = rsp_tvalid & rsp_tready;
   assign req_fire = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff <= '0;
      end else if (rsp_fire) begin
         exp_idx_ff <= rsp_tlast ? '0 : exp_idx_ff + 1'b1;
      end
   end

   a_word_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[34:32] == exp_idx_ff))
      else $error("digest word out of order");

   a_last_marks_fifth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == sha1s_pkg::IDX_LAST))
                     && (rsp_tdata[39:35] == 5'd0))
      else $error("last flag does not match word index");

   a_finish_stalls_input: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == sha1s_pkg::MODE_FINISH)) |=> !req_tready)
      else $error("input taken while padding");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind sha1_stream_hasher_top sha1s_checker u_checker (.*);
